// ===== sv/wls_pkg.sv =====
// Shared constants, codes and helpers for the wear-leveled slot store.
`timescale 1ns / 1ps
package wls_pkg;

    // Byte store depth; taken as a power of two so address wrap is truncation.
    localparam int MEM_BYTES         = 1024;
    localparam int ADDR_W            = $clog2(MEM_BYTES);
    localparam int MAX_ELEMENT_BYTES = 8;
    localparam int NUM_PARAMS        = 4;
    localparam int TABLE_REGS        = 4;

    localparam int PARAM0_RST_SLOTS = 5;
    localparam int PARAM1_RST_SLOTS = 3;

    localparam logic [31:0] SLOT_TABLE_0_RST = {16'h0000, 8'(PARAM0_RST_SLOTS), 8'd1};
    localparam logic [31:0] SLOT_TABLE_1_RST = {16'h000A, 8'(PARAM1_RST_SLOTS), 8'd2};
    localparam logic [31:0] SLOT_TABLE_2_RST = 32'h0000_0000;
    localparam logic [31:0] SLOT_TABLE_3_RST = 32'h0000_0000;

    localparam logic [7:0] ERASED_BYTE = 8'hFF;

    typedef logic [ADDR_W-1:0] addr_t;

    typedef enum logic [1:0] {
        CMD_RD_BYTE  = 2'd0,
        CMD_RD_WORD  = 2'd1,
        CMD_RD_BLOCK = 2'd2,
        CMD_WRITE    = 2'd3
    } cmd_e;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SKIPPED  = 2'd1,
        ST_MISMATCH = 2'd2,
        ST_INVALID  = 2'd3
    } status_e;

    // Byte-lane mask for an element of es bytes.
    function automatic logic [63:0] elem_mask(input logic [3:0] es);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (4'(i) < es)
            begin
                m[i*8 +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

// ===== sv/wls_ram.sv =====
// Single-port byte RAM with registered read data.
`timescale 1ns / 1ps
module wls_ram (
    input  logic             clk,
    input  logic             we,
    input  wls_pkg::addr_t   addr,
    input  logic [7:0]       wdata,
    output logic [7:0]       rdata
);
    import wls_pkg::*;

    logic [7:0] mem [MEM_BYTES];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/wear_leveled_slot_store.sv =====
// Top level of the wear-leveled slot store: command FSM around the byte RAM.
`timescale 1ns / 1ps
// Usage
//   Command channel: an item (cmd, param_index, req_size, data_in) is taken at a
//   clock edge with start high and busy low. Exactly one result per item comes
//   back on data_out/status with done high for a single cycle; the receiver
//   must take it then, there is no hold-off.
//   Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data writes one
//   of the four slot descriptors; cfg_ready is always high. Write only while
//   busy is low.
//   Sequence: an invalid descriptor or size mismatch answers in the cycle after
//   start. Otherwise the ring scan reads one status byte per cycle, then the
//   data bytes of the current slot are fetched. A write then compares them
//   with data_in and, if they differ, writes the status byte and data bytes
//   into the next slot of the ring. Every status byte, data byte and written
//   byte is one access to the single RAM port. One item at a time.
//   Reset: descriptors return to their defaults and the store runs an erase
//   sweep writing 0xFF to all 1024 bytes, one per cycle; busy stays high
//   throughout the sweep.
module wear_leveled_slot_store (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  cmd,
    input  logic [1:0]  param_index,
    input  logic [3:0]  req_size,
    input  logic [63:0] data_in,
    output logic        done,
    output logic [63:0] data_out,
    output logic [1:0]  status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import wls_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN0,
        S_SCAN,
        S_READ,
        S_CMP,
        S_WRITE
    } state_t;

    state_t      state_reg, state_next;
    addr_t       clr_reg, clr_next;
    logic [31:0] table_reg [TABLE_REGS];

    cmd_e        cmd_reg, cmd_next;
    logic [3:0]  req_reg, req_next;
    logic [63:0] data_reg, data_next;
    logic [3:0]  es_reg, es_next;
    logic [7:0]  cnt_reg, cnt_next;
    addr_t       base_reg, base_next;
    addr_t       probe_reg, probe_next;
    addr_t       chk_addr_reg, chk_addr_next;
    logic [7:0]  chk_k_reg, chk_k_next;
    addr_t       cur_addr_reg, cur_addr_next;
    logic [7:0]  cur_slot_reg, cur_slot_next;
    logic [7:0]  prev_reg, prev_next;
    logic [3:0]  nbytes_reg, nbytes_next;
    logic [3:0]  iss_i_reg, iss_i_next;
    logic        ret_valid_reg, ret_valid_next;
    logic [2:0]  ret_i_reg, ret_i_next;
    logic [63:0] acc_reg, acc_next;
    addr_t       wr_addr_reg, wr_addr_next;
    logic [3:0]  wr_i_reg, wr_i_next;
    logic        done_reg, done_next;
    logic [63:0] data_out_reg, data_out_next;
    status_e     status_reg, status_next;

    logic        mem_we;
    addr_t       mem_addr;
    logic [7:0]  mem_wdata;
    logic [7:0]  mem_rdata;

    logic [31:0] desc;
    logic [3:0]  in_es;
    logic [7:0]  in_cnt;
    addr_t       in_base;
    addr_t       stride;
    logic [2:0]  dsel;

    wls_ram u_ram (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign data_out  = data_out_reg;
    assign status    = status_reg;

    assign desc    = table_reg[param_index];
    assign in_es   = 4'(desc[7:0]);
    assign in_cnt  = desc[15:8];
    assign in_base = desc[16 +: ADDR_W];
    assign stride  = addr_t'(es_reg) + addr_t'(1);
    assign dsel    = 3'(wr_i_reg - 4'd1);

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        cmd_next       = cmd_reg;
        req_next       = req_reg;
        data_next      = data_reg;
        es_next        = es_reg;
        cnt_next       = cnt_reg;
        base_next      = base_reg;
        probe_next     = probe_reg;
        chk_addr_next  = chk_addr_reg;
        chk_k_next     = chk_k_reg;
        cur_addr_next  = cur_addr_reg;
        cur_slot_next  = cur_slot_reg;
        prev_next      = prev_reg;
        nbytes_next    = nbytes_reg;
        iss_i_next     = iss_i_reg;
        ret_valid_next = 1'b0;
        ret_i_next     = ret_i_reg;
        acc_next       = acc_reg;
        wr_addr_next   = wr_addr_reg;
        wr_i_next      = wr_i_reg;
        done_next      = 1'b0;
        data_out_next  = data_out_reg;
        status_next    = status_reg;
        mem_we         = 1'b0;
        mem_addr       = probe_reg;
        mem_wdata      = ERASED_BYTE;

        case (state_reg)
            S_CLEAR:
            begin
                mem_we   = 1'b1;
                mem_addr = clr_reg;
                clr_next = clr_reg + addr_t'(1);
                if (clr_reg == addr_t'(MEM_BYTES - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next  = cmd_e'(cmd);
                    req_next  = req_size;
                    data_next = data_in;
                    es_next   = in_es;
                    cnt_next  = in_cnt;
                    base_next = in_base;
                    if (int'(param_index) >= NUM_PARAMS || desc[7:0] == 8'd0 ||
                        int'(desc[7:0]) > MAX_ELEMENT_BYTES || in_cnt == 8'd0)
                    begin
                        done_next     = 1'b1;
                        data_out_next = '0;
                        status_next   = ST_INVALID;
                    end
                    else if ((cmd_e'(cmd) == CMD_RD_BYTE && in_es != 4'd1) ||
                             (cmd_e'(cmd) == CMD_RD_WORD && in_es != 4'd2))
                    begin
                        done_next     = 1'b1;
                        data_out_next = '0;
                        status_next   = ST_MISMATCH;
                    end
                    else
                    begin
                        // fetch the status byte at the ring base
                        mem_addr   = in_base;
                        probe_next = in_base + addr_t'(in_es) + addr_t'(1);
                        state_next = S_SCAN0;
                    end
                end
            end

            S_SCAN0:
            begin
                prev_next     = mem_rdata;
                cur_addr_next = base_reg;
                cur_slot_next = '0;
                if (cnt_reg == 8'd1)
                begin
                    state_next = S_READ;
                end
                else
                begin
                    mem_addr      = probe_reg;
                    chk_addr_next = probe_reg;
                    chk_k_next    = 8'd1;
                    probe_next    = probe_reg + stride;
                    state_next    = S_SCAN;
                end
            end

            S_SCAN:
            begin
                // rdata holds the status of slot chk_k; one probe in flight
                if (mem_rdata == prev_reg + 8'd1)
                begin
                    prev_next     = mem_rdata;
                    cur_addr_next = chk_addr_reg;
                    cur_slot_next = chk_k_reg;
                    if ({1'b0, chk_k_reg} + 9'd1 < {1'b0, cnt_reg})
                    begin
                        mem_addr      = probe_reg;
                        chk_addr_next = probe_reg;
                        chk_k_next    = chk_k_reg + 8'd1;
                        probe_next    = probe_reg + stride;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
                else
                begin
                    state_next = S_READ;
                end
            end

            S_READ:
            begin
                if (state_next == S_READ)
                begin
                    state_next = S_READ;
                end
                if (ret_valid_reg)
                begin
                    acc_next[{ret_i_reg, 3'b000} +: 8] = mem_rdata;
                end
                if (iss_i_reg < nbytes_reg)
                begin
                    mem_addr       = cur_addr_reg + addr_t'(1) + addr_t'(iss_i_reg);
                    ret_valid_next = 1'b1;
                    ret_i_next     = 3'(iss_i_reg);
                    iss_i_next     = iss_i_reg + 4'd1;
                end
                if (nbytes_reg == 4'd0 ||
                    (ret_valid_reg && ret_i_reg == 3'(nbytes_reg - 4'd1)))
                begin
                    state_next = S_CMP;
                end
            end

            S_CMP:
            begin
                if (cmd_reg != CMD_WRITE)
                begin
                    done_next     = 1'b1;
                    data_out_next = acc_reg;
                    status_next   = ST_OK;
                    state_next    = S_IDLE;
                end
                else if (acc_reg == (data_reg & elem_mask(es_reg)))
                begin
                    done_next     = 1'b1;
                    data_out_next = '0;
                    status_next   = ST_SKIPPED;
                    state_next    = S_IDLE;
                end
                else
                begin
                    if ({1'b0, cur_slot_reg} + 9'd1 >= {1'b0, cnt_reg})
                    begin
                        wr_addr_next = base_reg;
                    end
                    else
                    begin
                        wr_addr_next = cur_addr_reg + stride;
                    end
                    wr_i_next  = '0;
                    state_next = S_WRITE;
                end
            end

            S_WRITE:
            begin
                // status byte first, then data bytes ascending
                mem_we   = 1'b1;
                mem_addr = wr_addr_reg + addr_t'(wr_i_reg);
                if (wr_i_reg == 4'd0)
                begin
                    mem_wdata = prev_reg + 8'd1;
                end
                else
                begin
                    mem_wdata = data_reg[{dsel, 3'b000} +: 8];
                end
                wr_i_next = wr_i_reg + 4'd1;
                if (wr_i_reg == es_reg)
                begin
                    done_next     = 1'b1;
                    data_out_next = '0;
                    status_next   = ST_OK;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // set up the data fetch on entry to S_READ
        if (state_next == S_READ && state_reg != S_READ)
        begin
            iss_i_next     = '0;
            ret_valid_next = 1'b0;
            acc_next       = '0;
            if (cmd_reg == CMD_RD_BLOCK && req_reg < es_reg)
            begin
                nbytes_next = req_reg;
            end
            else
            begin
                nbytes_next = es_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            table_reg[0]  <= SLOT_TABLE_0_RST;
            table_reg[1]  <= SLOT_TABLE_1_RST;
            table_reg[2]  <= SLOT_TABLE_2_RST;
            table_reg[3]  <= SLOT_TABLE_3_RST;
            ret_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            ret_valid_reg <= ret_valid_next;
            done_reg      <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                table_reg[cfg_index] <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        req_reg      <= req_next;
        data_reg     <= data_next;
        es_reg       <= es_next;
        cnt_reg      <= cnt_next;
        base_reg     <= base_next;
        probe_reg    <= probe_next;
        chk_addr_reg <= chk_addr_next;
        chk_k_reg    <= chk_k_next;
        cur_addr_reg <= cur_addr_next;
        cur_slot_reg <= cur_slot_next;
        prev_reg     <= prev_next;
        nbytes_reg   <= nbytes_next;
        iss_i_reg    <= iss_i_next;
        ret_i_reg    <= ret_i_next;
        acc_reg      <= acc_next;
        wr_addr_reg  <= wr_addr_next;
        wr_i_reg     <= wr_i_next;
        data_out_reg <= data_out_next;
        status_reg   <= status_next;
    end

endmodule

// ===== tb/tb_wear_leveled_slot_store.sv =====
// Self-checking testbench for the wear-leveled slot store: directed and random command items.
`timescale 1ns / 1ps

module tb_wear_leveled_slot_store;
    import wls_pkg::*;

    typedef struct {
        logic [63:0] data;
        status_e     st;
    } slot_result_t;

    class slot_store_tracker;
        logic [7:0]   store_img [MEM_BYTES];
        logic [31:0]  desc [TABLE_REGS];
        slot_result_t awaited [$];
        int           mismatches;

        function new();
            foreach (store_img[i])
            begin
                store_img[i] = ERASED_BYTE;
            end
            desc[0] = SLOT_TABLE_0_RST;
            desc[1] = SLOT_TABLE_1_RST;
            desc[2] = SLOT_TABLE_2_RST;
            desc[3] = SLOT_TABLE_3_RST;
            mismatches = 0;
        endfunction

        function int wrap(int a);
            return a % MEM_BYTES;
        endfunction

        function void set_desc(logic [1:0] idx, logic [31:0] value);
            desc[idx] = value;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // Walk the status chain from the ring base; returns the current slot number.
        function int current_slot(int base, int es, int cnt);
            logic [7:0] prev;
            int         cur;
            cur  = 0;
            prev = store_img[wrap(base)];
            for (int k = 1; k < cnt; k++)
            begin
                if (store_img[wrap(base + k * (es + 1))] != prev + 8'd1)
                begin
                    break;
                end
                prev = store_img[wrap(base + k * (es + 1))];
                cur  = k;
            end
            return cur;
        endfunction

        function logic [63:0] fetch(int saddr, int n);
            logic [63:0] v;
            v = '0;
            for (int i = 0; i < n && i < 8; i++)
            begin
                v[8*i +: 8] = store_img[wrap(saddr + 1 + i)];
            end
            return v;
        endfunction

        function void note_request(cmd_e c, logic [1:0] idx, logic [3:0] req,
                                   logic [63:0] din);
            slot_result_t r;
            int           es, cnt, base, cur, saddr, nxt, naddr;
            logic [63:0]  mask, held;
            logic [7:0]   next_status;
            r.data = '0;
            r.st   = ST_OK;
            es     = int'(desc[idx][7:0]);
            cnt    = int'(desc[idx][15:8]);
            base   = int'(desc[idx][31:16]);
            if (idx >= NUM_PARAMS || es == 0 || es > MAX_ELEMENT_BYTES || cnt == 0)
            begin
                r.st = ST_INVALID;
            end
            else if ((c == CMD_RD_BYTE && es != 1) || (c == CMD_RD_WORD && es != 2))
            begin
                r.st = ST_MISMATCH;
            end
            else
            begin
                cur   = current_slot(base, es, cnt);
                saddr = wrap(base + cur * (es + 1));
                held  = fetch(saddr, es);
                if (c == CMD_RD_BLOCK)
                begin
                    r.data = fetch(saddr, (int'(req) < es) ? int'(req) : es);
                end
                else if (c == CMD_WRITE)
                begin
                    mask = '0;
                    for (int i = 0; i < es; i++)
                    begin
                        mask[8*i +: 8] = 8'hFF;
                    end
                    if (held == (din & mask))
                    begin
                        r.st = ST_SKIPPED;
                    end
                    else
                    begin
                        // status taken before any byte is overwritten (single-slot rings)
                        next_status = store_img[saddr] + 8'd1;
                        nxt   = (cur + 1 >= cnt) ? 0 : cur + 1;
                        naddr = wrap(base + nxt * (es + 1));
                        store_img[naddr] = next_status;
                        for (int i = 0; i < es; i++)
                        begin
                            store_img[wrap(naddr + 1 + i)] = din[8*i +: 8];
                        end
                    end
                end
                else
                begin
                    r.data = held;
                end
            end
            awaited.push_back(r);
        endfunction

        function void check_response(logic [63:0] d, logic [1:0] s);
            slot_result_t e;
            if (awaited.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual data_out=%h status=%0d",
                         $time, d, s);
                mismatches++;
            end
            else
            begin
                e = awaited.pop_front();
                if (d !== e.data)
                begin
                    $display("%0t: data_out mismatch: expected %h, actual %h",
                             $time, e.data, d);
                    mismatches++;
                end
                if (s !== e.st)
                begin
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, e.st, s);
                    mismatches++;
                end
            end
        endfunction
    endclass

    localparam logic [1:0] REG_SLOT_TABLE_0 = 2'd0;
    localparam logic [1:0] REG_SLOT_TABLE_1 = 2'd1;
    localparam logic [1:0] REG_SLOT_TABLE_2 = 2'd2;
    localparam logic [1:0] REG_SLOT_TABLE_3 = 2'd3;

    // parameters as laid out by the reset table
    localparam logic [1:0] PARAM_LCD   = 2'd0;
    localparam logic [1:0] PARAM_BAT   = 2'd1;
    localparam logic [1:0] PARAM_SPARE = 2'd2;
    localparam logic [1:0] PARAM_LAST  = 2'd3;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        start       = 1'b0;
    logic [1:0]  cmd         = '0;
    logic [1:0]  param_index = '0;
    logic [3:0]  req_size    = '0;
    logic [63:0] data_in     = '0;
    logic        cfg_valid   = 1'b0;
    logic [1:0]  cfg_index   = '0;
    logic [31:0] cfg_data    = '0;
    logic        busy;
    logic        done;
    logic [63:0] data_out;
    logic [1:0]  status;
    logic        cfg_ready;

    slot_store_tracker tracker = new();
    bit                idle_on = 1'b0;
    logic [63:0]       last_written [NUM_PARAMS];

    wear_leveled_slot_store u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .param_index (param_index),
        .req_size    (req_size),
        .data_in     (data_in),
        .done        (done),
        .data_out    (data_out),
        .status      (status),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            tracker.check_response(data_out, status);
        end
    end

    // Start stays high between back-to-back items; it only drops for a gap.
    task automatic send_item(input cmd_e c, input logic [1:0] idx, input logic [3:0] req,
                             input logic [63:0] din);
        while (idle_on && $urandom_range(99) < 18)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start       <= 1'b1;
        cmd         <= c;
        param_index <= idx;
        req_size    <= req;
        data_in     <= din;
        do @(posedge clk); while (busy);
        tracker.note_request(c, idx, req, din);
        if (c == CMD_WRITE)
        begin
            last_written[idx] = din;
        end
    endtask

    task automatic write_desc(input logic [1:0] idx, input logic [31:0] value);
        @(posedge clk);
        if (idle_on && $urandom_range(99) < 18)
        begin
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        tracker.set_desc(idx, value);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_table(input logic [31:0] d0, input logic [31:0] d1,
                              input logic [31:0] d2, input logic [31:0] d3);
        write_desc(REG_SLOT_TABLE_0, d0);
        write_desc(REG_SLOT_TABLE_1, d1);
        write_desc(REG_SLOT_TABLE_2, d2);
        write_desc(REG_SLOT_TABLE_3, d3);
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge clk); while (tracker.pending() != 0 || busy);
    endtask

    // Mostly valid rings of byte and word size with short chains; some invalid or long.
    function automatic logic [31:0] random_desc(input int p);
        logic [7:0]  es;
        logic [7:0]  cnt;
        logic [15:0] base;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 8)
        begin
            es = 8'($urandom_range(255));
        end
        else if (pick < 35)
        begin
            es = 8'd1;
        end
        else if (pick < 60)
        begin
            es = 8'd2;
        end
        else
        begin
            es = 8'($urandom_range(1, MAX_ELEMENT_BYTES));
        end
        pick = $urandom_range(99);
        if (pick < 5)
        begin
            cnt = 8'd0;
        end
        else if (pick < 12)
        begin
            cnt = 8'($urandom_range(1, 255));
        end
        else
        begin
            cnt = 8'($urandom_range(1, 12));
        end
        // upper base bits alias onto the same cells
        base = 16'(p * 256 + $urandom_range(0, 100) + 1024 * $urandom_range(0, 63));
        return {base, cnt, es};
    endfunction

    task automatic random_items(input int n);
        cmd_e        c;
        logic [1:0]  idx;
        logic [63:0] din;
        int          pick;
        for (int k = 0; k < n; k++)
        begin
            pick = $urandom_range(99);
            if (pick < 35)
            begin
                c = CMD_WRITE;
            end
            else if (pick < 60)
            begin
                c = CMD_RD_BLOCK;
            end
            else if (pick < 80)
            begin
                c = CMD_RD_BYTE;
            end
            else
            begin
                c = CMD_RD_WORD;
            end
            idx = 2'($urandom_range(3));
            din = {$urandom, $urandom};
            if ($urandom_range(99) < 15)
            begin
                din = last_written[idx];
            end
            send_item(c, idx, 4'($urandom_range(15)), din);
        end
    endtask

    initial
    begin
        foreach (last_written[i])
        begin
            last_written[i] = '1;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        // erase sweep
        do @(posedge clk); while (busy);
        idle_on = 1'b1;

        // reset descriptor table
        send_item(CMD_RD_BYTE, PARAM_LCD, 4'd0, '0);
        send_item(CMD_RD_WORD, PARAM_BAT, 4'd0, '0);
        send_item(CMD_RD_WORD, PARAM_LCD, 4'd0, '0);
        send_item(CMD_RD_BYTE, PARAM_BAT, 4'd0, '0);
        send_item(CMD_RD_BLOCK, PARAM_SPARE, 4'd8, '0);
        send_item(CMD_WRITE, PARAM_LAST, 4'd15, '1);
        send_item(CMD_WRITE, PARAM_LCD, 4'd0, 64'hFF);
        // run past the end of the five-slot ring
        for (int k = 0; k < 7; k++)
        begin
            send_item(CMD_WRITE, PARAM_LCD, 4'($urandom_range(15)),
                      {{$urandom, $urandom} & 64'hFFFF_FFFF_FFFF_FF00} | 64'(k * 37 + 1));
        end
        send_item(CMD_RD_BYTE, PARAM_LCD, 4'd0, '0);
        send_item(CMD_RD_BLOCK, PARAM_LCD, 4'd15, '0);
        send_item(CMD_WRITE, PARAM_BAT, 4'd0, 64'hFFFF_FFFF_FFFF_1234);
        send_item(CMD_RD_BLOCK, PARAM_BAT, 4'd0, '0);
        send_item(CMD_RD_BLOCK, PARAM_BAT, 4'd15, '0);
        send_item(CMD_RD_BLOCK, PARAM_BAT, 4'd1, '0);
        send_item(CMD_WRITE, PARAM_BAT, 4'd0, 64'h0000_0000_0000_1234);
        send_item(CMD_WRITE, PARAM_BAT, 4'd0, '0);
        send_item(CMD_RD_WORD, PARAM_BAT, 4'd0, '0);
        send_item(CMD_WRITE, PARAM_BAT, 4'd0, '1);
        send_item(CMD_RD_WORD, PARAM_BAT, 4'd0, '0);
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph == 0)
            begin
                // widest ring at the top of the address space, smallest ring, two bad entries
                load_table({16'hFFFF, 8'd255, 8'd8}, {16'h0000, 8'd1, 8'd1},
                           32'hFFFF_FFFF, {16'h8123, 8'd7, 8'd9});
            end
            else
            begin
                load_table(random_desc(0), random_desc(1), random_desc(2), random_desc(3));
            end
            idle_on = (ph != 3);
            random_items(240);
            drain();
        end

        repeat (300) @(posedge clk);
        if (tracker.mismatches == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial
    begin
        #25_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
